// ===== rtl/oaht_pkg.sv =====
// ----------------------------------------------------------------------------
// oaht_pkg: shared types and codes for the open addressing hash table
// Request and response words, the slot entry layout, command, status and
// slot state codes.
// ----------------------------------------------------------------------------
package oaht_pkg;

    // Fixed field widths
    localparam int HASH_W  = 32;
    localparam int KEY_W   = 32;
    localparam int VALUE_W = 64;
    localparam int LIMIT_W = 6;

    // Occupancy limit after reset
    localparam logic [LIMIT_W-1:0] MAX_COUNT_RESET = 6'd48;

    // Command codes (code 3 is unused and answers not found)
    localparam logic [1:0] CMD_GET = 2'd0;
    localparam logic [1:0] CMD_SET = 2'd1;
    localparam logic [1:0] CMD_DEL = 2'd2;

    // Response status codes
    localparam logic [2:0] ST_FOUND     = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_INSERTED  = 3'd2;
    localparam logic [2:0] ST_UPDATED   = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    // Slot state codes
    localparam logic [1:0] SLOT_EMPTY = 2'd0;
    localparam logic [1:0] SLOT_LIVE  = 2'd1;
    localparam logic [1:0] SLOT_TOMB  = 2'd2;

    // Request word
    typedef struct packed {
        logic [1:0]         cmd;
        logic [KEY_W-1:0]   key_id;
        logic [HASH_W-1:0]  key_hash;
        logic [VALUE_W-1:0] write_value;
    } req_t;

    // Response word
    typedef struct packed {
        logic [2:0]         status;
        logic [VALUE_W-1:0] read_value;
    } rsp_t;

    // One table slot as held in memory
    typedef struct packed {
        logic [1:0]         state;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } slot_t;

endpackage

// ===== rtl/oaht_hash_mod.sv =====
// ----------------------------------------------------------------------------
// oaht_hash_mod: home slot from key hash
// Reduces the 32-bit hash modulo CAPACITY. A power-of-two capacity takes the
// low bits, registered; any other capacity multiplies by a fixed reciprocal
// and subtracts the quotient multiple through hash, product, quotient and
// remainder registers. done pulses for one cycle with rem valid.
// ----------------------------------------------------------------------------
module oaht_hash_mod #(
    parameter  int CAPACITY = 64,
    localparam int IW       = $clog2(CAPACITY)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [oaht_pkg::HASH_W-1:0] hash,
    output logic                       done,
    output logic [IW-1:0]              rem
);
    import oaht_pkg::*;

    generate
        if ((CAPACITY & (CAPACITY - 1)) == 0) begin : g_mask
            logic          done_reg;
            logic [IW-1:0] rem_reg;

            // Done pulse in the cycle after start
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= start;
                end
            end

            // Low hash bits are the remainder
            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    rem_reg <= hash[IW-1:0];
                end
            end

            assign done = done_reg;
            assign rem  = rem_reg;
        end
        else begin : g_recip
            // Rounded-up reciprocal, fits 32 bits for a non-power-of-two size
            localparam int SHIFT = IW - 1;
            localparam logic [HASH_W-1:0] MAGIC =
                HASH_W'((64'd1 << HASH_W) * 64'((2 ** IW) - CAPACITY)
                        / 64'(CAPACITY) + 64'd1);
            localparam logic [HASH_W-1:0] CAP_W = HASH_W'(CAPACITY);

            logic [3:0]          stage_reg;
            logic [HASH_W-1:0]   n_reg;
            logic [HASH_W-1:0]   t1_reg;
            logic [HASH_W-1:0]   q_reg;
            logic [HASH_W-1:0]   q_next;
            logic [IW-1:0]       rem_reg;
            logic [2*HASH_W-1:0] prod;
            logic [HASH_W-1:0]   qc;

            // Reciprocal product, quotient fixup and quotient multiple
            always_comb
            begin
                prod   = (2*HASH_W)'(n_reg) * (2*HASH_W)'(MAGIC);
                q_next = (t1_reg + ((n_reg - t1_reg) >> 1)) >> SHIFT;
                qc     = q_reg * CAP_W;
            end

            // Stage valid bits; the last one is the done pulse
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    stage_reg <= '0;
                end
                else
                begin
                    stage_reg <= {stage_reg[2:0], start};
                end
            end

            // Datapath
            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    n_reg <= hash;
                end
                if (stage_reg[0])
                begin
                    t1_reg <= prod[2*HASH_W-1:HASH_W];
                end
                if (stage_reg[1])
                begin
                    q_reg <= q_next;
                end
                if (stage_reg[2])
                begin
                    rem_reg <= n_reg[IW-1:0] - qc[IW-1:0];
                end
            end

            assign done = stage_reg[3];
            assign rem  = rem_reg;
        end
    endgenerate

endmodule

// ===== rtl/oaht_slot_mem.sv =====
// ----------------------------------------------------------------------------
// oaht_slot_mem: slot storage
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module oaht_slot_mem #(
    parameter  int CAPACITY = 64,
    localparam int IW       = $clog2(CAPACITY)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [IW-1:0]        waddr,
    input  oaht_pkg::slot_t      wdata,
    input  logic [IW-1:0]        raddr,
    output oaht_pkg::slot_t      rdata
);
    import oaht_pkg::*;

    slot_t mem [CAPACITY];
    slot_t rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/open_addressing_hash_table_core.sv =====
// Each command probes P slots (1..CAPACITY), one slot per cycle, once the
// home slot is reduced from the hash; an unused command code is answered
// without a probe. For get, set and delete, busy is high from accept until
// the response strobe, and the next word can be accepted in the strobe
// cycle. The receiver cannot stall.
// After reset a clearing pass over every slot runs with busy high.
// ----------------------------------------------------------------------------
// open_addressing_hash_table_core: fixed-size key/value table
// Linear probing with tombstones; get, set and delete commands; new inserts
// into empty slots bounded by the max_count occupancy register.
// ----------------------------------------------------------------------------
module open_addressing_hash_table_core #(
    parameter int CAPACITY = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  oaht_pkg::req_t                req,
    output logic                          done,
    output oaht_pkg::rsp_t                rsp,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [oaht_pkg::LIMIT_W-1:0]  cfg_data
);
    import oaht_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int UW = $clog2(CAPACITY + 1);
    localparam int CW = (UW > LIMIT_W) ? UW : LIMIT_W;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_MOD   = 4'b0100,
        S_PROBE = 4'b1000
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [IW-1:0]        clr_idx_reg;
    logic [IW-1:0]        idx_reg;
    logic [IW-1:0]        idx_next;
    logic [IW-1:0]        idx_inc;
    logic [IW-1:0]        n_reg;
    logic [IW-1:0]        n_next;
    logic                 tomb_seen_reg;
    logic                 tomb_seen_next;
    logic [IW-1:0]        tomb_at_reg;
    logic [IW-1:0]        tomb_at_next;
    logic [UW-1:0]        used_count_reg;
    logic                 used_inc;
    logic [LIMIT_W-1:0]   max_count_reg;
    logic                 done_reg;
    logic                 done_next;
    rsp_t                 rsp_reg;
    rsp_t                 rsp_next;
    logic [1:0]           cmd_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [VALUE_W-1:0]   wval_reg;

    logic                 accept;
    logic                 cmd_ok;
    logic                 mod_start;
    logic                 mod_done;
    logic [IW-1:0]        mod_rem;

    logic                 mem_we;
    logic [IW-1:0]        mem_waddr;
    slot_t                mem_wdata;
    logic [IW-1:0]        mem_raddr;
    slot_t                slot;

    logic                 hit;
    logic                 is_tomb;
    logic                 is_empty;
    logic                 last;
    logic                 probe_end;
    logic                 room;

    // Handshakes
    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cmd_ok    = (req.cmd == CMD_GET) || (req.cmd == CMD_SET) ||
                       (req.cmd == CMD_DEL);
    assign mod_start = accept && cmd_ok;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign rsp       = rsp_reg;

    // Home slot unit
    oaht_hash_mod #(
        .CAPACITY (CAPACITY)
    ) u_hash_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .hash  (req.key_hash),
        .done  (mod_done),
        .rem   (mod_rem)
    );

    // Slot memory
    oaht_slot_mem #(
        .CAPACITY (CAPACITY)
    ) u_slot_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (slot)
    );

    // Probe step decode on the slot read this cycle
    always_comb
    begin
        idx_inc  = (idx_reg == IW'(CAPACITY - 1)) ? '0 : (idx_reg + 1'b1);
        hit      = (slot.state == SLOT_LIVE) && (slot.key == key_reg);
        is_tomb  = (slot.state == SLOT_TOMB);
        is_empty = (slot.state != SLOT_LIVE) && !is_tomb;
        last     = (n_reg == IW'(CAPACITY - 1));
        probe_end = hit || is_empty || last;
        room     = CW'(used_count_reg) < CW'(max_count_reg);
        tomb_seen_next = tomb_seen_reg || is_tomb;
        tomb_at_next   = tomb_seen_reg ? tomb_at_reg : idx_reg;
    end

    // Read address runs one slot ahead of the decode
    always_comb
    begin
        case (state_reg)
            S_MOD:   mem_raddr = mod_rem;
            S_PROBE: mem_raddr = idx_inc;
            default: mem_raddr = idx_reg;
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        n_next     = n_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_idx_reg == IW'(CAPACITY - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (mod_start)
                begin
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    state_next = S_PROBE;
                    idx_next   = mod_rem;
                    n_next     = '0;
                end
            end
            S_PROBE:
            begin
                if (probe_end)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_inc;
                    n_next   = n_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outcome, slot write and response
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = '0;
        used_inc  = 1'b0;
        done_next = 1'b0;
        rsp_next  = rsp_reg;
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_reg;
        end
        else if (accept && !cmd_ok)
        begin
            done_next = 1'b1;
            rsp_next  = '{status: ST_NOT_FOUND, read_value: '0};
        end
        else if ((state_reg == S_PROBE) && probe_end)
        begin
            done_next = 1'b1;
            rsp_next  = '{status: ST_NOT_FOUND, read_value: '0};
            case (cmd_reg)
                CMD_GET:
                begin
                    if (hit)
                    begin
                        rsp_next = '{status: ST_FOUND, read_value: slot.value};
                    end
                end
                CMD_SET:
                begin
                    mem_wdata = '{state: SLOT_LIVE, key: key_reg, value: wval_reg};
                    if (hit)
                    begin
                        mem_we          = 1'b1;
                        rsp_next.status = ST_UPDATED;
                    end
                    else if (tomb_seen_next)
                    begin
                        mem_we          = 1'b1;
                        mem_waddr       = tomb_at_next;
                        rsp_next.status = ST_INSERTED;
                    end
                    else if (is_empty && room)
                    begin
                        mem_we          = 1'b1;
                        used_inc        = 1'b1;
                        rsp_next.status = ST_INSERTED;
                    end
                    else
                    begin
                        rsp_next.status = ST_FULL;
                    end
                end
                CMD_DEL:
                begin
                    mem_wdata = '{state: SLOT_TOMB, key: slot.key, value: slot.value};
                    if (hit)
                    begin
                        mem_we          = 1'b1;
                        rsp_next.status = ST_FOUND;
                    end
                end
                default:
                begin
                    rsp_next.status = ST_NOT_FOUND;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_idx_reg    <= '0;
            n_reg          <= '0;
            tomb_seen_reg  <= 1'b0;
            used_count_reg <= '0;
            max_count_reg  <= MAX_COUNT_RESET;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            done_reg  <= done_next;
            if (state_reg == S_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (state_reg == S_MOD)
            begin
                tomb_seen_reg <= 1'b0;
            end
            else if (state_reg == S_PROBE)
            begin
                tomb_seen_reg <= tomb_seen_next;
            end
            if (used_inc)
            begin
                used_count_reg <= used_count_reg + 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                max_count_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        rsp_reg <= rsp_next;
        if (accept)
        begin
            cmd_reg  <= req.cmd;
            key_reg  <= req.key_id;
            wval_reg <= req.write_value;
        end
        if (state_reg == S_PROBE)
        begin
            tomb_at_reg <= tomb_at_next;
        end
    end

`ifndef ASSERT_OFF
    // Response strobe only once the block is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("response strobe while busy");

    // Slot writes only during clearing or at the end of a probe
    a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_CLEAR) || (state_reg == S_PROBE))
        else $error("slot write outside clear or probe");

    // Occupancy never passes the table size
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_count_reg <= UW'(CAPACITY))
        else $error("occupancy count beyond capacity");

    // Occupancy grows only on an insert that reports inserted
    a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
        used_inc |=> done && (rsp.status == ST_INSERTED))
        else $error("occupancy grew without an insert");

    // A response always carries a defined status
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.status <= ST_FULL))
        else $error("undefined response status");
`endif

endmodule
